// File: design/kts_pkg.sv
package kts_pkg;

    // Command codes carried on the input beat.
    localparam logic [1:0] CMD_RECORD   = 2'd0;
    localparam logic [1:0] CMD_SNAPSHOT = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    // Status codes carried on the result beat.
    localparam logic [2:0] STS_RECORDED   = 3'd0;
    localparam logic [2:0] STS_CREATED    = 3'd1;
    localparam logic [2:0] STS_DROPPED    = 3'd2;
    localparam logic [2:0] STS_CLEARED    = 3'd3;
    localparam logic [2:0] STS_SNAP_ENTRY = 3'd4;
    localparam logic [2:0] STS_SNAP_EMPTY = 3'd5;

    // One entry's statistics, as held in the statistics memory.
    typedef struct packed {
        logic [31:0] calls;
        logic [47:0] total;
        logic [31:0] latest;
        logic [31:0] worst;
        logic [31:0] least;
    } t_stats;

    // Statistics of a freshly cleared entry; least starts at all ones.
    localparam t_stats STATS_CLEAR = '{
        calls:  32'd0,
        total:  48'd0,
        latest: 32'd0,
        worst:  32'd0,
        least:  32'hFFFF_FFFF
    };

endpackage

// File: design/kts_ram.sv
module kts_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/kts_update.sv
module kts_update
    import kts_pkg::*;
(
    input  t_stats      i_old,
    input  logic        i_fresh,
    input  logic [31:0] i_elapsed,
    output t_stats      o_new
);

    t_stats base;

    // A newly allocated slot starts from cleared statistics, not from memory.
    always_comb begin
        base         = i_fresh ? STATS_CLEAR : i_old;
        o_new.calls  = base.calls + 32'd1;
        o_new.total  = base.total + {16'd0, i_elapsed};
        o_new.latest = i_elapsed;
        o_new.worst  = (i_elapsed > base.worst) ? i_elapsed : base.worst;
        o_new.least  = (i_elapsed < base.least) ? i_elapsed : base.least;
    end

endmodule

// File: design/keyed_timing_stats_table.sv
// A record searches the allocated keys, then updates the slot it found or allocates a new one.
// A snapshot gives one result beat per allocated entry; a statistics clear sweeps the allocated slots, then reports.
// Throughput: one command at a time; the key search visits one slot per cycle of the key memory.
// The next input beat is taken as soon as the last result sits in the output register.
// Reset (synchronous, active low) empties the table and the output register; the memories
// themselves are not swept, since a slot is always written in full when it is allocated.
module keyed_timing_stats_table
    import kts_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_section_key,
    input  logic [31:0] i_elapsed,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_entry_index,
    output logic [31:0] o_entry_key,
    output logic [31:0] o_entry_calls,
    output logic [47:0] o_entry_total,
    output logic [31:0] o_entry_latest,
    output logic [31:0] o_entry_worst,
    output logic [31:0] o_entry_least,
    output logic [6:0]  o_entry_count,
    output logic        o_last_of_run
);

    // Slot address width and the width of a count that can reach the capacity.
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] CAPACITY = CW'(MAX_ENTRIES);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b000_0001,
        ST_SEARCH   = 7'b000_0010,
        ST_MODIFY   = 7'b000_0100,
        ST_EMIT     = 7'b000_1000,
        ST_CLEAR    = 7'b001_0000,
        ST_SNAP_RD  = 7'b010_0000,
        ST_SNAP_OUT = 7'b100_0000
    } t_state;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  index;
        logic [31:0] key;
        t_stats      stats;
        logic [6:0]  count;
        logic        last;
    } t_result;

    t_state        r_state, n_state;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_cmp_idx, n_cmp_idx;
    logic          r_cmp_valid, n_cmp_valid;
    logic          r_created, n_created;
    logic [31:0]   r_key, n_key;
    logic [31:0]   r_dur, n_dur;
    logic [2:0]    r_status, n_status;

    logic          r_out_valid;
    t_result       r_out;
    t_result       res;
    logic          res_fire;
    logic          out_free;
    logic          hit;

    logic          key_we;
    logic [31:0]   key_rdata;
    logic          stats_we;
    logic [AW-1:0] stats_waddr;
    logic [AW-1:0] stats_raddr;
    t_stats        stats_wdata;
    t_stats        stats_rdata;
    t_stats        upd_stats;

    // Key memory: written once when a slot is allocated. Its read address
    // is always the walking index, which serves both the key search and
    // the snapshot walk.
    kts_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ENTRIES),
        .ADDR_W(AW)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(r_cmp_idx),
        .i_wdata(r_key),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(key_rdata)
    );

    // Statistics memory: one packed record per slot, read-modify-written
    // by a record command and overwritten by the clear sweep.
    kts_ram #(
        .WIDTH ($bits(t_stats)),
        .DEPTH (MAX_ENTRIES),
        .ADDR_W(AW)
    ) u_stats_ram (
        .i_clk  (i_clk),
        .i_we   (stats_we),
        .i_waddr(stats_waddr),
        .i_wdata(stats_wdata),
        .i_raddr(stats_raddr),
        .o_rdata(stats_rdata)
    );

    kts_update u_update (
        .i_old    (stats_rdata),
        .i_fresh  (r_created),
        .i_elapsed(r_dur),
        .o_new    (upd_stats)
    );

    // The output register takes a new result whenever it is empty or its
    // current beat leaves this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // The key read data in this cycle belongs to slot r_cmp_idx, whose read was issued in the cycle before.
    assign hit = r_cmp_valid && (key_rdata == r_key);

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_valid = r_cmp_valid;
        n_created   = r_created;
        n_key       = r_key;
        n_dur       = r_dur;
        n_status    = r_status;

        key_we      = 1'b0;
        stats_we    = 1'b0;
        stats_waddr = r_cmp_idx;
        stats_wdata = upd_stats;
        stats_raddr = r_cmp_idx;

        res_fire    = 1'b0;
        res         = '0;
        res.count   = 7'(r_used);

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_key       = i_section_key;
                    n_dur       = i_elapsed;
                    n_idx       = '0;
                    n_cmp_valid = 1'b0;
                    case (i_cmd)
                        CMD_RECORD: begin
                            n_state = ST_SEARCH;
                        end
                        CMD_SNAPSHOT: begin
                            if (r_used == '0) begin
                                n_status = STS_SNAP_EMPTY;
                                n_state  = ST_EMIT;
                            end else begin
                                n_state = ST_SNAP_RD;
                            end
                        end
                        CMD_CLEAR: begin
                            n_state = ST_CLEAR;
                        end
                        default: begin
                            // The unused command code is taken and dropped
                            // without a result.
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                // Reads are issued one slot per cycle, each compared in the cycle
                // after. On a hit the statistics read of that slot goes out
                // in the same cycle, so the data is ready in ST_MODIFY.
                if (hit) begin
                    n_created = 1'b0;
                    n_state   = ST_MODIFY;
                end else if (r_idx < r_used) begin
                    n_cmp_idx   = r_idx[AW-1:0];
                    n_idx       = r_idx + CW'(1);
                    n_cmp_valid = 1'b1;
                end else if (r_used == CAPACITY) begin
                    n_status = STS_DROPPED;
                    n_state  = ST_EMIT;
                end else begin
                    // Miss with room left: the next free slot is allocated.
                    n_created = 1'b1;
                    n_cmp_idx = r_used[AW-1:0];
                    n_state   = ST_MODIFY;
                end
            end

            ST_MODIFY: begin
                // The read address stays on the slot, so the read data holds
                // while the output register is busy.
                if (out_free) begin
                    stats_we   = 1'b1;
                    key_we     = r_created;
                    n_used     = r_created ? r_used + CW'(1) : r_used;
                    res_fire   = 1'b1;
                    res.status = r_created ? STS_CREATED : STS_RECORDED;
                    res.index  = 6'(r_cmp_idx);
                    res.key    = r_key;
                    res.stats  = upd_stats;
                    res.count  = 7'(r_created ? r_used + CW'(1) : r_used);
                    res.last   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            ST_EMIT: begin
                // Single-beat answers that carry no entry: a sample dropped
                // on a full table, or a snapshot of an empty one.
                if (out_free) begin
                    res_fire   = 1'b1;
                    res.status = r_status;
                    res.key    = (r_status == STS_DROPPED) ? r_key : 32'd0;
                    res.last   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            ST_CLEAR: begin
                // Sweep the allocated slots one per cycle, then report.
                stats_waddr = r_idx[AW-1:0];
                stats_wdata = STATS_CLEAR;
                if (r_idx < r_used) begin
                    stats_we = 1'b1;
                    n_idx    = r_idx + CW'(1);
                end else if (out_free) begin
                    res_fire   = 1'b1;
                    res.status = STS_CLEARED;
                    res.last   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            ST_SNAP_RD: begin
                stats_raddr = r_idx[AW-1:0];
                n_state     = ST_SNAP_OUT;
            end

            ST_SNAP_OUT: begin
                stats_raddr = r_idx[AW-1:0];
                if (out_free) begin
                    res_fire   = 1'b1;
                    res.status = STS_SNAP_ENTRY;
                    res.index  = 6'(r_idx[AW-1:0]);
                    res.key    = key_rdata;
                    res.stats  = stats_rdata;
                    res.last   = ((r_idx + CW'(1)) == r_used);
                    n_idx      = r_idx + CW'(1);
                    n_state    = ((r_idx + CW'(1)) == r_used) ? ST_IDLE : ST_SNAP_RD;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (res_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_cmp_valid <= n_cmp_valid;
        r_created   <= n_created;
        r_key       <= n_key;
        r_dur       <= n_dur;
        r_status    <= n_status;
        if (res_fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_entry_index  = r_out.index;
    assign o_entry_key    = r_out.key;
    assign o_entry_calls  = r_out.stats.calls;
    assign o_entry_total  = r_out.stats.total;
    assign o_entry_latest = r_out.stats.latest;
    assign o_entry_worst  = r_out.stats.worst;
    assign o_entry_least  = r_out.stats.least;
    assign o_entry_count  = r_out.count;
    assign o_last_of_run  = r_out.last;

    // The table never holds more entries than its capacity.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CAPACITY)
        else $error("entry count exceeds capacity");

    // An allocation grows the table by exactly one entry.
    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MODIFY && res_fire && r_created)
        |=> (r_used == $past(r_used) + CW'(1)))
        else $error("allocation did not add exactly one entry");

    // The snapshot walk reports allocated slots only.
    a_snap_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SNAP_OUT) |-> (r_idx < r_used))
        else $error("snapshot index beyond allocated entries");

    // The key search never runs past the allocated slots.
    a_search_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_idx <= r_used))
        else $error("key search index beyond allocated entries");

endmodule
